// File: rtl/core/rpe_pkg.sv
package rpe_pkg;

	// Default table geometry
	localparam int MAX_POSITIONS_DEF = 2048;
	localparam int MAX_PAIRS_DEF     = 64;

	// Fixed field widths
	localparam int POS_W    = 11;
	localparam int PAIR_W   = 6;
	localparam int PAIRS_W  = 7;
	localparam int DATA_W   = 16;
	localparam int CFG_W    = 11;
	localparam int ENTRY_W  = 2 * DATA_W;

	// Queue between front and back
	localparam int QDEPTH   = 4;
	localparam int QIDX_W   = 2;
	localparam int QCNT_W   = 3;

	// Configuration register indices
	localparam logic CFG_POSITION_OFFSET = 1'b0;
	localparam logic CFG_PAIRS_IN_USE    = 1'b1;

	// Item function codes
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_ROTATE = 1'b1;

	// Reset value of pairs in use
	localparam logic [PAIRS_W-1:0] PAIRS_RESET = PAIRS_W'(64);

	// One rotate operation handed from front to back
	typedef struct packed {
		logic signed [DATA_W-1:0] x_even;
		logic signed [DATA_W-1:0] x_odd;
		logic signed [DATA_W-1:0] cos_v;
		logic signed [DATA_W-1:0] sin_v;
		logic                     oor;
	} rpe_op_t;

endpackage

// File: rtl/core/rpe_ram.sv
module rpe_ram import rpe_pkg::*; #(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = MAX_POSITIONS_DEF * MAX_PAIRS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/rpe_queue.sv
module rpe_queue import rpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rpe_op_t           push_data,
	input  logic              pop,
	output rpe_op_t           pop_data,
	output logic              not_empty,
	output logic [QCNT_W-1:0] count
);

	rpe_op_t            slot_q [QDEPTH];
	logic [QIDX_W-1:0]  wr_ptr_q;
	logic [QIDX_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QIDX_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QIDX_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data  = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

// File: rtl/core/rpe_front.sv
module rpe_front import rpe_pkg::*; #(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
	parameter int MAX_PAIRS     = MAX_PAIRS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     func,
	input  logic [POS_W-1:0]         position,
	input  logic [PAIR_W-1:0]        pair_index,
	input  logic signed [DATA_W-1:0] x_even,
	input  logic signed [DATA_W-1:0] x_odd,
	input  logic signed [DATA_W-1:0] cos_word,
	input  logic signed [DATA_W-1:0] sin_word,
	input  logic [QCNT_W-1:0]        q_count,
	output logic                     push,
	output rpe_op_t                  push_data
);

	localparam int DEPTH = MAX_POSITIONS * MAX_PAIRS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [POS_W-1:0]         offset_q;
	logic [PAIRS_W-1:0]       pairs_q;
	logic [POS_W:0]           pos_sum;
	logic [POS_W:0]           addr_pos;
	logic                     accept;
	logic                     rot_oor;
	logic                     ld_ok;
	logic                     ram_we;
	logic                     ram_re;
	logic [AW-1:0]            addr;
	logic [ENTRY_W-1:0]       rdata;
	logic                     valid_s1;
	logic                     oor_s1;
	logic signed [DATA_W-1:0] x_even_s1;
	logic signed [DATA_W-1:0] x_odd_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			pairs_q  <= PAIRS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POSITION_OFFSET: offset_q <= cfg_wdata;
				CFG_PAIRS_IN_USE:    pairs_q  <= cfg_wdata[PAIRS_W-1:0];
				default: ;
			endcase
		end
	end

	// credit: queued ops plus the one waiting on the table read
	assign in_stall = ({1'b0, q_count} + (QCNT_W+1)'(valid_s1)) >= (QCNT_W+1)'(QDEPTH);
	assign accept   = in_valid && !in_stall;

	assign pos_sum = {1'b0, position} + {1'b0, offset_q};
	assign rot_oor = (32'(pos_sum) >= 32'(MAX_POSITIONS))
		|| ({1'b0, pair_index} >= pairs_q)
		|| (32'(pair_index) >= 32'(MAX_PAIRS));
	assign ld_ok   = (32'(position) < 32'(MAX_POSITIONS))
		&& (32'(pair_index) < 32'(MAX_PAIRS));

	assign addr_pos = (func == FUNC_ROTATE) ? pos_sum : {1'b0, position};
	assign addr     = AW'(32'(addr_pos) * 32'(MAX_PAIRS) + 32'(pair_index));
	assign ram_we   = accept && (func == FUNC_LOAD) && ld_ok;
	assign ram_re   = accept && (func == FUNC_ROTATE) && !rot_oor;

	rpe_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata ({cos_word, sin_word}),
		.re    (ram_re),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (func == FUNC_ROTATE);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			oor_s1    <= rot_oor;
			x_even_s1 <= x_even;
			x_odd_s1  <= x_odd;
		end
	end

	assign push             = valid_s1;
	assign push_data.x_even = x_even_s1;
	assign push_data.x_odd  = x_odd_s1;
	assign push_data.cos_v  = rdata[ENTRY_W-1:DATA_W];
	assign push_data.sin_v  = rdata[DATA_W-1:0];
	assign push_data.oor    = oor_s1;

endmodule

// File: rtl/core/rpe_back.sv
module rpe_back import rpe_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_not_empty,
	input  rpe_op_t                  q_data,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] y_even,
	output logic signed [DATA_W-1:0] y_odd,
	output logic                     out_of_range
);

	logic                     advance;
	logic                     valid_s1;
	logic                     oor_s1;
	logic signed [31:0]       xc_e_s1;
	logic signed [31:0]       xs_o_s1;
	logic signed [31:0]       xs_e_s1;
	logic signed [31:0]       xc_o_s1;
	logic signed [33:0]       acc_even;
	logic signed [33:0]       acc_odd;
	logic signed [DATA_W-1:0] sat_even;
	logic signed [DATA_W-1:0] sat_odd;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] y_even_q;
	logic signed [DATA_W-1:0] y_odd_q;
	logic                     oor_q;

	// round half up, floor shift to Q1.15, clamp
	function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [33:0] acc);
		logic signed [33:0] shifted;
		logic signed [18:0] q;
		shifted = acc >>> 15;
		q       = shifted[18:0];
		if (q > 19'sd32767) begin
			return 16'sh7FFF;
		end else if (q < -19'sd32768) begin
			return 16'sh8000;
		end else begin
			return q[DATA_W-1:0];
		end
	endfunction

	// whole back pipe holds while a valid output is stalled
	assign advance = !(out_valid_q && out_stall);
	assign pop     = q_not_empty && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop;
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			oor_s1  <= q_data.oor;
			xc_e_s1 <= q_data.x_even * q_data.cos_v;
			xs_o_s1 <= q_data.x_odd * q_data.sin_v;
			xs_e_s1 <= q_data.x_even * q_data.sin_v;
			xc_o_s1 <= q_data.x_odd * q_data.cos_v;
		end
	end

	assign acc_even = 34'(xc_e_s1) - 34'(xs_o_s1) + 34'sd16384;
	assign acc_odd  = 34'(xs_e_s1) + 34'(xc_o_s1) + 34'sd16384;
	assign sat_even = round_sat(acc_even);
	assign sat_odd  = round_sat(acc_odd);

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			y_even_q <= oor_s1 ? '0 : sat_even;
			y_odd_q  <= oor_s1 ? '0 : sat_odd;
			oor_q    <= oor_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign y_even       = y_even_q;
	assign y_odd        = y_odd_q;
	assign out_of_range = oor_q;

endmodule

// File: rtl/core/rotary_position_embedding_core.sv
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_we                cfg_index, cfg_wdata
// in        in         in_valid / in_stall   func, position, pair_index, x_*, cos_word, sin_word
// out       out        out_valid / out_stall y_even, y_odd, out_of_range
//
// One item per cycle sustained while in_stall is low. A rotate item's result passes the
// table read register at the accepting edge, then the queue, product and round/saturate
// registers; a load gives no result.
// The angle table is a simple dual-port RAM; each item makes at most one access to it.
// Reset clears control and configuration only; table contents are undefined until loaded.
// out_stall freezes the back pipe; the front keeps taking items until the four-entry
// queue, counted with the read in flight, is full, then raises in_stall.
module rotary_position_embedding_core import rpe_pkg::*; #(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
	parameter int MAX_PAIRS     = MAX_PAIRS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration writes
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_W-1:0]         cfg_wdata,
	// input items
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     func,
	input  logic [POS_W-1:0]         position,
	input  logic [PAIR_W-1:0]        pair_index,
	input  logic signed [DATA_W-1:0] x_even,
	input  logic signed [DATA_W-1:0] x_odd,
	input  logic signed [DATA_W-1:0] cos_word,
	input  logic signed [DATA_W-1:0] sin_word,
	// result items
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] y_even,
	output logic signed [DATA_W-1:0] y_odd,
	output logic                     out_of_range
);

	logic              push;
	rpe_op_t           push_data;
	logic              pop;
	rpe_op_t           pop_data;
	logic              q_not_empty;
	logic [QCNT_W-1:0] q_count;

	// front: config, range check, table load/lookup
	rpe_front #(
		.MAX_POSITIONS (MAX_POSITIONS),
		.MAX_PAIRS     (MAX_PAIRS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.position   (position),
		.pair_index (pair_index),
		.x_even     (x_even),
		.x_odd      (x_odd),
		.cos_word   (cos_word),
		.sin_word   (sin_word),
		.q_count    (q_count),
		.push       (push),
		.push_data  (push_data)
	);

	// decoupling queue of rotate ops
	rpe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	// back: four multiplies, then sum, round and saturate
	rpe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_data       (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.y_even       (y_even),
		.y_odd        (y_odd),
		.out_of_range (out_of_range)
	);

endmodule
